>>> hw/rtl/srl_pkg.sv
// Shared types, constants and codes for the sorted ranking list.
// Used by the controller, the datapath and the top level; depends on nothing.
package srl_pkg;

  // List geometry.
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned TAG_BITS = 8;
  localparam int unsigned KEY_BITS = 32;

  localparam int unsigned IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_BITS = TAG_BITS + KEY_BITS;

  // Fixed field widths on the streams.
  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned IN_TAG_BITS    = 8;
  localparam int unsigned IN_REWARD_BITS = 32;
  localparam int unsigned RANK_BITS      = 4;
  localparam int unsigned STATUS_BITS    = 2;
  localparam int unsigned COUNT_BITS     = 5;

  localparam int unsigned IN_TDATA_BITS  = 48;
  localparam int unsigned OUT_TDATA_BITS = 48;

  // Width used to compare a rank against the count.
  localparam int unsigned CMP_BITS = (CNT_BITS > RANK_BITS) ? CNT_BITS : RANK_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_INS_RD,
    CS_INS_CMP,
    CS_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RA_PREV,
    RA_LAST,
    RA_RANK
  } rd_addr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         capture;
    logic         idx_load;
    logic         rd_en;
    rd_addr_sel_e rd_sel;
    logic         wr_en;
    logic         wr_shift;
    logic         idx_dec;
    logic         finish;
  } srl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic err;
    logic idx_zero;
    logic stored_ge;
    logic out_free;
  } srl_status_t;

endpackage

>>> hw/rtl/sorted_ranking_list_top.sv
// Top level of the sorted ranking list: controller plus datapath.
// Depends on srl_pkg, srl_controller, srl_datapath and srl_ram.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   op, agent_tag, reward, rank
//   m_axis    out        m_axis_tvalid/m_axis_tready   status, entry_tag, entry_reward, count
//
// Reads, removes, refused requests and the unused op pass through decode and finish,
// where the result is registered. An insert walks the RAM from the tail, reading and
// shifting down one entry at a time, and writes the new entry when it reaches the head
// or lands behind an entry of equal or higher reward.
// One request is in flight at a time; reset clears the count and needs no sweep.
// A held result stalls the block only if it is still untaken when the next is due.
module sorted_ranking_list_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // op [1:0], agent_tag [9:2], reward [41:10], rank [45:42], zero [47:46]
  input  logic [srl_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status [1:0], entry_tag [9:2], entry_reward [41:10], count [46:42], zero [47]
  output logic [srl_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
  import srl_pkg::*;

  srl_cmd_t    cmd;
  srl_status_t status;

  // Sequencer.
  srl_controller u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Storage and result path.
  srl_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

>>> hw/rtl/srl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module srl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/srl_datapath.sv
// Datapath of the sorted ranking list: request registers, entry RAM,
// count, walk index and result register. Depends on srl_pkg and srl_ram.
module srl_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [srl_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [srl_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  input  srl_pkg::srl_cmd_t                    cmd_i,
  output srl_pkg::srl_status_t                 status_o
);
  import srl_pkg::*;

  // Captured request.
  op_e                           op_q;
  logic [TAG_BITS-1:0]           tag_q;
  logic signed [KEY_BITS-1:0]    key_q;
  logic [RANK_BITS-1:0]          rank_q;

  // List state.
  logic [CNT_BITS-1:0]           count_q, count_d;
  logic [IDX_BITS-1:0]           idx_q;

  // Result register.
  logic                          m_valid_q;
  status_e                       res_status_q;
  logic [IN_TAG_BITS-1:0]        res_tag_q;
  logic signed [IN_REWARD_BITS-1:0] res_reward_q;
  logic [COUNT_BITS-1:0]         res_count_q;

  // RAM signals.
  logic [IDX_BITS-1:0]           raddr, waddr;
  logic [ENTRY_BITS-1:0]         wdata, rdata;
  logic [TAG_BITS-1:0]           rd_tag;
  logic signed [KEY_BITS-1:0]    rd_key;

  status_e                       dec_status;
  logic                          ok;

  // Field slices of the incoming request.
  logic [OP_BITS-1:0]            in_op;
  logic [IN_TAG_BITS-1:0]        in_tag;
  logic signed [IN_REWARD_BITS-1:0] in_reward;
  logic [RANK_BITS-1:0]          in_rank;

  assign in_op     = s_axis_tdata[1:0];
  assign in_tag    = s_axis_tdata[9:2];
  assign in_reward = $signed(s_axis_tdata[41:10]);
  assign in_rank   = s_axis_tdata[45:42];

  // Request capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NOP;
    end else if (cmd_i.capture) begin
      op_q <= op_e'(in_op);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q  <= TAG_BITS'(in_tag);
      key_q  <= KEY_BITS'(in_reward);
      rank_q <= in_rank;
    end
  end

  // Status of the captured request against the current count.
  always_comb begin
    dec_status = STS_OK;
    case (op_q)
      OP_INSERT: begin
        if (count_q == CNT_BITS'(DEPTH)) dec_status = STS_FULL;
      end
      OP_REMOVE: begin
        if (count_q == '0) dec_status = STS_EMPTY;
      end
      OP_READ: begin
        if (CMP_BITS'(rank_q) >= CMP_BITS'(count_q)) dec_status = STS_RANGE;
      end
      default: dec_status = STS_OK;
    endcase
  end

  assign ok = (dec_status == STS_OK);

  // Entry RAM; each word holds the key above the tag.
  always_comb begin
    case (cmd_i.rd_sel)
      RA_PREV: raddr = idx_q - IDX_BITS'(1);
      RA_LAST: raddr = IDX_BITS'(count_q - CNT_BITS'(1));
      RA_RANK: raddr = IDX_BITS'(rank_q);
      default: raddr = idx_q;
    endcase
  end

  assign waddr = idx_q;
  assign wdata = cmd_i.wr_shift ? rdata : {key_q, tag_q};

  srl_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_tag = rdata[TAG_BITS-1:0];
  assign rd_key = $signed(rdata[ENTRY_BITS-1:TAG_BITS]);

  // Walk index for the insertion shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load) begin
      idx_q <= IDX_BITS'(count_q);
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - IDX_BITS'(1);
    end
  end

  // Count after the request completes.
  always_comb begin
    count_d = count_q;
    if (ok && op_q == OP_INSERT) count_d = count_q + CNT_BITS'(1);
    if (ok && op_q == OP_REMOVE) count_d = count_q - CNT_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= dec_status;
      res_count_q  <= COUNT_BITS'(count_d);
      if (ok && (op_q == OP_REMOVE || op_q == OP_READ)) begin
        res_tag_q    <= IN_TAG_BITS'(rd_tag);
        res_reward_q <= IN_REWARD_BITS'(rd_key);
      end else begin
        res_tag_q    <= '0;
        res_reward_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_count_q, res_reward_q, res_tag_q, res_status_q};

  // Status towards the controller.
  assign status_o.op        = op_q;
  assign status_o.err       = !ok;
  assign status_o.idx_zero  = (idx_q == '0);
  assign status_o.stored_ge = (rd_key >= key_q);
  assign status_o.out_free  = !m_valid_q || m_axis_tready;

endmodule

>>> hw/rtl/srl_controller.sv
// Controller state machine of the sorted ranking list.
// Depends on srl_pkg; drives the datapath through srl_cmd_t.
module srl_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  srl_pkg::srl_status_t  status_i,
  output srl_pkg::srl_cmd_t     cmd_o
);
  import srl_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (s_axis_tvalid) state_d = CS_DECODE;
      end
      CS_DECODE: begin
        if (!status_i.err && status_i.op == OP_INSERT) state_d = CS_INS_RD;
        else state_d = CS_FINISH;
      end
      CS_INS_RD: begin
        if (status_i.idx_zero) state_d = CS_FINISH;
        else state_d = CS_INS_CMP;
      end
      CS_INS_CMP: begin
        if (status_i.stored_ge) state_d = CS_FINISH;
        else state_d = CS_INS_RD;
      end
      CS_FINISH: begin
        if (status_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = RA_PREV;
    s_axis_tready = 1'b0;
    case (state_q)
      CS_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      CS_DECODE: begin
        // Start the walk from the end, or fetch the entry to return.
        if (!status_i.err) begin
          case (status_i.op)
            OP_INSERT: cmd_o.idx_load = 1'b1;
            OP_REMOVE: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_LAST;
            end
            OP_READ: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_RANK;
            end
            default: cmd_o.rd_en = 1'b0;
          endcase
        end
      end
      CS_INS_RD: begin
        // At the head the new entry goes straight in.
        if (status_i.idx_zero) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PREV;
        end
      end
      CS_INS_CMP: begin
        // Stop behind an entry of equal or higher reward, else shift it down.
        cmd_o.wr_en = 1'b1;
        if (!status_i.stored_ge) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_dec  = 1'b1;
        end
      end
      CS_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
